/* design/assert_macros.svh */
// Assertion macros shared by the transcoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define U2CP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("u2cp assertion failed");

// next-cycle implication
`define U2CP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("u2cp assertion failed");

`endif

/* design/u2cp_pkg.sv */
// Package: types, constants and code page lookup for the UTF-8 transcoder
package u2cp_pkg;

	localparam int CpW = 21;
	localparam logic [31:0] CP_LIMIT = 32'h0010_ffff;
	localparam logic [7:0] QMARK = 8'h3f;

	localparam logic [1:0] PAGE_1252 = 2'd0;
	localparam logic [1:0] PAGE_1251 = 2'd1;
	localparam logic [1:0] PAGE_1250 = 2'd2;
	localparam logic [1:0] PAGE_NONE = 2'd3;
	localparam int NumPages = 3;

	typedef struct packed {
		logic           dec_vld;
		logic [CpW-1:0] dec_cp;
		logic           eos;
		logic           end_ok;
		logic [CpW-1:0] end_cp;
	} u2cp_item_t;

	localparam logic [15:0] PAGE_TAB [NumPages][128] = '{
		'{
		16'h20ac, 16'h0081, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
		16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008d, 16'h017d, 16'h008f,
		16'h0090, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
		16'h02dc, 16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'h009d, 16'h017e, 16'h0178,
		16'h00a0, 16'h00a1, 16'h00a2, 16'h00a3, 16'h00a4, 16'h00a5, 16'h00a6, 16'h00a7,
		16'h00a8, 16'h00a9, 16'h00aa, 16'h00ab, 16'h00ac, 16'h00ad, 16'h00ae, 16'h00af,
		16'h00b0, 16'h00b1, 16'h00b2, 16'h00b3, 16'h00b4, 16'h00b5, 16'h00b6, 16'h00b7,
		16'h00b8, 16'h00b9, 16'h00ba, 16'h00bb, 16'h00bc, 16'h00bd, 16'h00be, 16'h00bf,
		16'h00c0, 16'h00c1, 16'h00c2, 16'h00c3, 16'h00c4, 16'h00c5, 16'h00c6, 16'h00c7,
		16'h00c8, 16'h00c9, 16'h00ca, 16'h00cb, 16'h00cc, 16'h00cd, 16'h00ce, 16'h00cf,
		16'h00d0, 16'h00d1, 16'h00d2, 16'h00d3, 16'h00d4, 16'h00d5, 16'h00d6, 16'h00d7,
		16'h00d8, 16'h00d9, 16'h00da, 16'h00db, 16'h00dc, 16'h00dd, 16'h00de, 16'h00df,
		16'h00e0, 16'h00e1, 16'h00e2, 16'h00e3, 16'h00e4, 16'h00e5, 16'h00e6, 16'h00e7,
		16'h00e8, 16'h00e9, 16'h00ea, 16'h00eb, 16'h00ec, 16'h00ed, 16'h00ee, 16'h00ef,
		16'h00f0, 16'h00f1, 16'h00f2, 16'h00f3, 16'h00f4, 16'h00f5, 16'h00f6, 16'h00f7,
		16'h00f8, 16'h00f9, 16'h00fa, 16'h00fb, 16'h00fc, 16'h00fd, 16'h00fe, 16'h00ff
		},
		'{
		16'h0402, 16'h0403, 16'h201a, 16'h0453, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
		16'h20ac, 16'h2030, 16'h0409, 16'h2039, 16'h040a, 16'h040c, 16'h040b, 16'h040f,
		16'h0452, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
		16'h0098, 16'h2122, 16'h0459, 16'h203a, 16'h045a, 16'h045c, 16'h045b, 16'h045f,
		16'h00a0, 16'h040e, 16'h045e, 16'h0408, 16'h00a4, 16'h0490, 16'h00a6, 16'h00a7,
		16'h0401, 16'h00a9, 16'h0404, 16'h00ab, 16'h00ac, 16'h00ad, 16'h00ae, 16'h0407,
		16'h00b0, 16'h00b1, 16'h0406, 16'h0456, 16'h0491, 16'h00b5, 16'h00b6, 16'h00b7,
		16'h0451, 16'h2116, 16'h0454, 16'h00bb, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
		16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
		16'h0418, 16'h0419, 16'h041a, 16'h041b, 16'h041c, 16'h041d, 16'h041e, 16'h041f,
		16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
		16'h0428, 16'h0429, 16'h042a, 16'h042b, 16'h042c, 16'h042d, 16'h042e, 16'h042f,
		16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
		16'h0438, 16'h0439, 16'h043a, 16'h043b, 16'h043c, 16'h043d, 16'h043e, 16'h043f,
		16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
		16'h0448, 16'h0449, 16'h044a, 16'h044b, 16'h044c, 16'h044d, 16'h044e, 16'h044f
		},
		'{
		16'h20ac, 16'h0081, 16'h201a, 16'h0083, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
		16'h0088, 16'h2030, 16'h0160, 16'h2039, 16'h015a, 16'h0164, 16'h017d, 16'h0179,
		16'h0090, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
		16'h0098, 16'h2122, 16'h0161, 16'h203a, 16'h015b, 16'h0165, 16'h017e, 16'h017a,
		16'h00a0, 16'h02c7, 16'h02d8, 16'h0141, 16'h00a4, 16'h0104, 16'h00a6, 16'h00a7,
		16'h00a8, 16'h00a9, 16'h015e, 16'h00ab, 16'h00ac, 16'h00ad, 16'h00ae, 16'h017b,
		16'h00b0, 16'h00b1, 16'h02db, 16'h0142, 16'h00b4, 16'h00b5, 16'h00b6, 16'h00b7,
		16'h00b8, 16'h0105, 16'h015f, 16'h00bb, 16'h013d, 16'h02dd, 16'h013e, 16'h017c,
		16'h0154, 16'h00c1, 16'h00c2, 16'h0102, 16'h00c4, 16'h0139, 16'h0106, 16'h00c7,
		16'h010c, 16'h00c9, 16'h0118, 16'h00cb, 16'h011a, 16'h00cd, 16'h00ce, 16'h010e,
		16'h0110, 16'h0143, 16'h0147, 16'h00d3, 16'h00d4, 16'h0150, 16'h00d6, 16'h00d7,
		16'h0158, 16'h016e, 16'h00da, 16'h0170, 16'h00dc, 16'h00dd, 16'h0162, 16'h00df,
		16'h0155, 16'h00e1, 16'h00e2, 16'h0103, 16'h00e4, 16'h013a, 16'h0107, 16'h00e7,
		16'h010d, 16'h00e9, 16'h0119, 16'h00eb, 16'h011b, 16'h00ed, 16'h00ee, 16'h010f,
		16'h0111, 16'h0144, 16'h0148, 16'h00f3, 16'h00f4, 16'h0151, 16'h00f6, 16'h00f7,
		16'h0159, 16'h016f, 16'h00fa, 16'h0171, 16'h00fc, 16'h00fd, 16'h0163, 16'h02d9
		}
	};

	// lowest matching table index wins; unknown page matches nothing
	function automatic logic [7:0] map_point(input logic [CpW-1:0] cp, input logic [1:0] page);
		logic [7:0] res;
		res = QMARK;
		if (cp <= CpW'(8'hff)) begin
			res = cp[7:0];
		end else begin
			for (int p = 0; p < NumPages; p++) begin
				for (int i = 127; i >= 0; i--) begin
					if (page == 2'(p) && cp[CpW-1:16] == '0 && cp[15:0] == PAGE_TAB[p][i]) begin
						res = {1'b1, 7'(i)};
					end
				end
			end
		end
		return res;
	endfunction

endpackage

/* design/u2cp_accum.sv */
// Code point accumulator: gathers UTF-8 bytes and forms the decisions of one beat
module u2cp_accum import u2cp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  logic [7:0]   in_byte,
	input  logic         end_of_string,
	output u2cp_item_t   item
);

	logic [31:0] accum_q;
	logic        pending_q;
	logic [31:0] accum_nxt;
	logic        cont;

	assign cont = (in_byte & 8'hc0) == 8'h80;

	always_comb begin
		if (in_byte <= 8'h7f) begin
			accum_nxt = {24'd0, in_byte};
		end else if (in_byte <= 8'hbf) begin
			accum_nxt = {accum_q[25:0], in_byte[5:0]};
		end else if (in_byte <= 8'hdf) begin
			accum_nxt = {27'd0, in_byte[4:0]};
		end else if (in_byte <= 8'hef) begin
			accum_nxt = {28'd0, in_byte[3:0]};
		end else begin
			accum_nxt = {29'd0, in_byte[2:0]};
		end
	end

	always_comb begin
		item.dec_vld = pending_q && !cont && (accum_q <= CP_LIMIT);
		item.dec_cp  = accum_q[CpW-1:0];
		item.eos     = end_of_string;
		item.end_ok  = accum_nxt <= CP_LIMIT;
		item.end_cp  = accum_nxt[CpW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q   <= '0;
			pending_q <= 1'b0;
		end else if (accept) begin
			// drop the accumulated value at string end
			accum_q   <= end_of_string ? 32'd0 : accum_nxt;
			pending_q <= !end_of_string;
		end
	end

endmodule

/* design/u2cp_emit.sv */
// Result stage: holds up to two results of a beat, maps them and drives the output register
module u2cp_emit import u2cp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  u2cp_item_t  item,
	input  logic [1:0]  code_page,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        last
);

	logic           dec_pend_s1;
	logic           end_pend_s1;
	logic [CpW-1:0] dec_cp_s1;
	logic [CpW-1:0] end_cp_s1;
	logic           end_ok_s1;

	logic           out_vld_q;
	logic [7:0]     out_byte_q;
	logic           byte_vld_q;
	logic           last_q;

	logic           has;
	logic           load;
	logic [CpW-1:0] sel_cp;
	logic [7:0]     mapped;

	assign has      = dec_pend_s1 || end_pend_s1;
	assign load     = has && (!out_vld_q || out_ready);
	assign in_ready = !has || (load && !(dec_pend_s1 && end_pend_s1));
	assign sel_cp   = dec_pend_s1 ? dec_cp_s1 : end_cp_s1;
	assign mapped   = map_point(sel_cp, code_page);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_pend_s1 <= 1'b0;
			end_pend_s1 <= 1'b0;
		end else if (accept) begin
			dec_pend_s1 <= item.dec_vld;
			end_pend_s1 <= item.eos;
		end else if (load) begin
			if (dec_pend_s1) begin
				dec_pend_s1 <= 1'b0;
			end else begin
				end_pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_cp_s1 <= item.dec_cp;
			end_cp_s1 <= item.end_cp;
			end_ok_s1 <= item.end_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (dec_pend_s1) begin
				out_byte_q <= mapped;
				byte_vld_q <= 1'b1;
				last_q     <= 1'b0;
			end else begin
				out_byte_q <= end_ok_s1 ? mapped : 8'd0;
				byte_vld_q <= end_ok_s1;
				last_q     <= 1'b1;
			end
		end
	end

	assign out_valid  = out_vld_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_vld_q;
	assign last       = last_q;

endmodule

/* design/utf8_to_codepage_decoder_top.sv */
// Top level of the UTF-8 to single-byte code page transcoder
// Usage:
//   Input channel (in_valid/in_ready): one UTF-8 byte per beat in in_byte,
//   end_of_string high on the final byte of a string.
//   Output channel (out_valid/out_ready): one result per beat; out_byte is a
//   code page byte when byte_valid is high, last marks the end of a string.
//   A beat yields zero, one or two results.
//   cfg_wr_en/cfg_wr_data select the code page (0 cp1252, 1 cp1251,
//   2 cp1250, 3 unknown); write only while the block is idle.
// Timing:
//   Results pass through the result stage, then the output register. One input
//   beat is taken per cycle while each beat yields at most one result and out_ready
//   holds nothing back; a beat with two results stalls input until the single output
//   register takes the second. Code page lookup is a combinational constant compare over 128 entries.
// Reset:
//   arst_n clears the accumulator, the pending flag, all held results and
//   selects cp1252.
// Stall:
//   While out_ready is low the output register holds its result, one beat
//   more waits in the result stage, and in_ready drops after that.
`include "assert_macros.svh"

module utf8_to_codepage_decoder_top import u2cp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       last,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data
);

	logic [1:0] code_page_q;
	logic       accept;
	u2cp_item_t item;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_page_q <= PAGE_1252;
		end else if (cfg_wr_en) begin
			code_page_q <= cfg_wr_data;
		end
	end

	u2cp_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.item          (item)
	);

	u2cp_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.code_page  (code_page_q),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.last       (last)
	);

	`U2CP_ASSERT_IMPL(a_novalid_is_last, clk, arst_n, out_valid && !byte_valid, last)
	`U2CP_ASSERT_IMPL(a_novalid_zero, clk, arst_n, out_valid && !byte_valid, out_byte == 8'd0)
	`U2CP_ASSERT_NEXT(a_backpressure_has_out, clk, arst_n, !in_ready, out_valid)

endmodule
